[sv/dhc_pkg.sv]
// Shared types and constants for the depth and hue color codec.
package dhc_pkg;

  typedef enum logic {
    FuncEncode = 1'b0,
    FuncDecode = 1'b1
  } func_t;

  localparam int TdataW = 40;
  localparam int QuantW = 5;
  localparam int HueW = 11;

  localparam logic [HueW-1:0] HueSpan = 11'd1529;
  localparam logic [HueW-1:0] HueSeg1 = 11'd255;
  localparam logic [HueW-1:0] HueSeg2 = 11'd510;
  localparam logic [HueW-1:0] HueSeg3 = 11'd765;
  localparam logic [HueW-1:0] HueSeg4 = 11'd1020;
  localparam logic [HueW-1:0] HueSeg5 = 11'd1275;
  localparam logic [9:0] DarkSum = 10'd255;

  localparam logic [QuantW-1:0] QuantMin = 5'd1;
  localparam logic [QuantW-1:0] QuantMax = 5'd16;
  localparam logic [QuantW-1:0] QuantReset = 5'd16;

  localparam int RecipShift = 40;
  localparam longint unsigned RecipDiv = 64'd3058;
  localparam longint unsigned RecipFull =
    ((64'd1 << RecipShift) + RecipDiv - 64'd1) / RecipDiv;
  localparam logic [28:0] QuantRecip = RecipFull[28:0];

  function automatic logic [QuantW-1:0] quant_clamp(input logic [QuantW-1:0] q);
    logic [QuantW-1:0] res;
    res = q;
    if (q < QuantMin) begin
      res = QuantMin;
    end else if (q > QuantMax) begin
      res = QuantMax;
    end
    return res;
  endfunction

endpackage

[sv/depth_hue_codec_core.sv]
// Top level of the depth and hue color codec: a five-register streaming pipeline.
//
// The in_ channel carries one item per handshake: in_tuser selects encode (0) or
// decode (1), in_tdata holds the depth and the red, green and blue channels, and
// in_tlast marks the end of a frame. The out_ channel returns exactly one item
// for each input item, in order, with the decoded depth and the encoded colors
// in out_tdata and the frame marker in out_tlast.
// The cfg_ channel writes the quantization bit count; write it only while the
// pipeline is empty. It is always ready.
// Throughput is one item per clock while the receiver does not stall. An item
// passes through an input register, three work stages and the result register.
// The decode path uses the reciprocal multiply that replaces the division in
// the rounding step.
// Reset clears all valid bits and sets the bit count to 16. When the receiver
// stalls, each stage holds while it is full and the stage after it holds, so
// bubbles are squeezed out and in_tready drops only when all five stages hold items.
module depth_hue_codec_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: depth_in[15:0], red_in[23:16], green_in[31:24], blue_in[39:32].
  input  logic [dhc_pkg::TdataW-1:0] in_tdata,
  // Fields from bit 0: func.
  input  logic [0:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: depth_out[15:0], red_out[23:16], green_out[31:24], blue_out[39:32].
  output logic [dhc_pkg::TdataW-1:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [dhc_pkg::QuantW-1:0] cfg_data
);

  import dhc_pkg::*;

  logic [QuantW-1:0] quant_r;
  logic [QuantW-1:0] qc;
  logic [QuantW-1:0] qs_up;
  logic [QuantW-1:0] qs_down;

  logic rdy1, rdy2, rdy3, rdy4;

  logic        v0_r, v1_r, v2_r, v3_r, out_vld_r;
  func_t       func0_r, func1_r, func2_r, func3_r;
  logic        last0_r, last1_r, last2_r, last3_r, out_last_r;
  logic [15:0] depth0_r;
  logic [7:0]  red0_r, green0_r, blue0_r;

  logic [26:0] prod1_r, prod1_nxt;
  logic [HueW-1:0] h1_r, h1_nxt;
  logic [9:0]  sum1;

  logic [27:0] quot2_sum;
  logic [HueW-1:0] d2_r, d2_nxt;
  logic [27:0] x2_r, x2_nxt;

  logic [7:0]  red3_r, red3_nxt, green3_r, green3_nxt, blue3_r, blue3_nxt;
  logic [56:0] p3_r, p3_nxt;

  logic [16:0] n4;
  logic [16:0] v4;
  logic [15:0] depth4;
  logic [TdataW-1:0] out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_r <= QuantReset;
    end else if (cfg_valid) begin
      quant_r <= cfg_data;
    end
  end

  assign qc = quant_clamp(quant_r);
  assign qs_up = qc + QuantMin;
  assign qs_down = QuantMax - qc;

  assign rdy4 = !out_vld_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = !v0_r || rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        v0_r <= in_tvalid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        out_vld_r <= v3_r;
      end
    end
  end

  always_comb begin
    prod1_nxt = 27'(depth0_r) * 27'(HueSpan);
    sum1 = 10'(red0_r) + 10'(green0_r) + 10'(blue0_r);
    if (sum1 < DarkSum) begin
      h1_nxt = '0;
    end else if (red0_r >= green0_r && red0_r >= blue0_r) begin
      if (green0_r >= blue0_r) begin
        h1_nxt = HueW'(green0_r) - HueW'(blue0_r);
      end else begin
        h1_nxt = HueW'(green0_r) + HueSpan - HueW'(blue0_r);
      end
    end else if (green0_r >= red0_r && green0_r >= blue0_r) begin
      h1_nxt = HueW'(blue0_r) + HueSeg2 - HueW'(red0_r);
    end else begin
      h1_nxt = HueW'(red0_r) + HueSeg4 - HueW'(green0_r);
    end
  end

  always_comb begin
    quot2_sum = 28'(prod1_r) + 28'(prod1_r[26:16]) + 28'd1;
    d2_nxt = quot2_sum[26:16];
    x2_nxt = (28'(h1_r) << qs_up) + 28'(HueSpan);
  end

  always_comb begin
    if (d2_r <= HueSeg1 || d2_r > HueSeg5) begin
      red3_nxt = 8'hFF;
    end else if (d2_r <= HueSeg2) begin
      red3_nxt = 8'(HueSeg2 - d2_r);
    end else if (d2_r <= HueSeg4) begin
      red3_nxt = 8'h00;
    end else begin
      red3_nxt = 8'(d2_r - HueSeg4);
    end

    if (d2_r <= HueSeg1) begin
      green3_nxt = 8'(d2_r);
    end else if (d2_r <= HueSeg3) begin
      green3_nxt = 8'hFF;
    end else if (d2_r <= HueSeg4) begin
      green3_nxt = 8'(HueSeg4 - d2_r);
    end else begin
      green3_nxt = 8'h00;
    end

    if (d2_r <= HueSeg2) begin
      blue3_nxt = 8'h00;
    end else if (d2_r <= HueSeg3) begin
      blue3_nxt = 8'(d2_r - HueSeg2);
    end else if (d2_r <= HueSeg5) begin
      blue3_nxt = 8'hFF;
    end else begin
      blue3_nxt = 8'(HueSpan - d2_r);
    end

    p3_nxt = 57'(x2_r) * 57'(QuantRecip);
  end

  always_comb begin
    n4 = p3_r[56:RecipShift];
    v4 = 17'(n4 << qs_down);
    depth4 = v4[16] ? 16'hFFFF : v4[15:0];
    if (func3_r == FuncDecode) begin
      out_data_nxt = {24'h000000, depth4};
    end else begin
      out_data_nxt = {blue3_r, green3_r, red3_r, 16'h0000};
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      func0_r <= func_t'(in_tuser[0]);
      last0_r <= in_tlast;
      depth0_r <= in_tdata[15:0];
      red0_r <= in_tdata[23:16];
      green0_r <= in_tdata[31:24];
      blue0_r <= in_tdata[39:32];
    end
    if (rdy1) begin
      func1_r <= func0_r;
      last1_r <= last0_r;
      prod1_r <= prod1_nxt;
      h1_r <= h1_nxt;
    end
    if (rdy2) begin
      func2_r <= func1_r;
      last2_r <= last1_r;
      d2_r <= d2_nxt;
      x2_r <= x2_nxt;
    end
    if (rdy3) begin
      func3_r <= func2_r;
      last3_r <= last2_r;
      red3_r <= red3_nxt;
      green3_r <= green3_nxt;
      blue3_r <= blue3_nxt;
      p3_r <= p3_nxt;
    end
    if (rdy4) begin
      out_last_r <= last3_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule
